// ===== rtl/core/monte_carlo_option_path_engine_top_assert.svh =====
// Assertion macros used by the path engine checker.
`ifndef MONTE_CARLO_OPTION_PATH_ENGINE_TOP_ASSERT_SVH
`define MONTE_CARLO_OPTION_PATH_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MCOPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MCOPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mcope_pkg.sv =====
// Shared types, constants and helper functions of the option path engine.
`timescale 1ns / 1ps
package mcope_pkg;

  localparam int MAX_STEPS_DEF = 4096;
  localparam int PSUM_W        = 44;
  localparam int TOTAL_W       = 63;
  localparam int MUL_W         = 34;

  localparam logic [31:0] SPOT_RST  = 32'd6553600;
  localparam logic [31:0] STRIKE_RST = 32'd6553600;
  localparam logic [16:0] BUMP_RST  = 17'd655;
  localparam logic [30:0] VOL_RST   = 31'd26770000;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

  typedef enum logic [2:0] {
    REG_SPOT   = 3'd0,
    REG_STRIKE = 3'd1,
    REG_BUMP   = 3'd2,
    REG_DRIFT  = 3'd3,
    REG_VOL    = 3'd4,
    REG_STEPS  = 3'd5,
    REG_KIND   = 3'd6,
    REG_PATHS  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_CALL       = 3'd0,
    KIND_PUT        = 3'd1,
    KIND_FIXED_CALL = 3'd2,
    KIND_FIXED_PUT  = 3'd3,
    KIND_FLOAT_CALL = 3'd4,
    KIND_FLOAT_PUT  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XMUL,
    ST_TRUNC,
    ST_LOG,
    ST_TMUL,
    ST_TREG,
    ST_PMUL,
    ST_PREC,
    ST_PCOR,
    ST_GMUL,
    ST_GAPPLY,
    ST_CHECK,
    ST_DIV,
    ST_PAY
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // floor(2^32 / n) for the Taylor divisors one to six.
  function automatic logic [32:0] recip(input logic [2:0] n);
    logic [32:0] r;
    case (n)
      3'd1:    r = 33'h1_0000_0000;
      3'd2:    r = 33'h0_8000_0000;
      3'd3:    r = 33'd1431655765;
      3'd4:    r = 33'h0_4000_0000;
      3'd5:    r = 33'd858993459;
      3'd6:    r = 33'd715827882;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] start_up(input logic [31:0] spot, input logic [16:0] bump);
    logic [32:0] s;
    s = {1'b0, spot} + {16'b0, bump};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] start_down(input logic [31:0] spot, input logic [16:0] bump);
    return (spot > {15'b0, bump}) ? spot - {15'b0, bump} : 32'd0;
  endfunction

endpackage

// ===== rtl/core/mcope_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module mcope_mul (
  input  logic                                  clk,
  input  logic signed [mcope_pkg::MUL_W-1:0]    a,
  input  logic signed [mcope_pkg::MUL_W-1:0]    b,
  output logic signed [2*mcope_pkg::MUL_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/core/mcope_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle in each lane.
`timescale 1ns / 1ps
module mcope_div #(
  parameter int SW = mcope_pkg::PSUM_W,
  parameter int DW = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DW-1:0]         divisor,
  input  logic [SW-1:0]         dividend [3],
  output logic [SW-1:0]         quotient [3],
  output mcope_pkg::div_stat_t  stat
);

  localparam int CW = $clog2(SW + 1);

  logic [DW:0]   rem [3];
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   rem_sh [3];
  logic          bit_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem[i][DW-1:0], quotient[i][SW-1]};
      bit_q[i]  = (rem_sh[i] >= {1'b0, divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (start) begin
        quotient[i] <= dividend[i];
        rem[i]      <= '0;
      end else if (busy) begin
        rem[i]      <= bit_q[i] ? rem_sh[i] - {1'b0, divisor} : rem_sh[i];
        quotient[i] <= {quotient[i][SW-2:0], bit_q[i]};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/monte_carlo_option_path_engine_top.sv =====
// Top level of the Monte Carlo option path engine.
`timescale 1ns / 1ps
// Each normal_sample word advances three price paths (base, spot plus bump, spot minus bump)
// by one day. sample_ready stays low after a sample is accepted until the engine is back in
// idle: first the exponent (three multiplies), then the sixth-order series of 2^f, the three
// price updates and the day count, all on one shared 34 by 34 bit multiplier. The sample that
// ends a path then waits on a three-lane restoring divider that forms the average prices, and
// then on the load of payoffs and totals into the result register. That load
// waits only while the previous result word is still unaccepted; once loaded, the word may
// wait for result_ready while the next path is already being simulated.
module monte_carlo_option_path_engine_top #(
  parameter int MAX_STEPS = mcope_pkg::MAX_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic signed [15:0]  normal_sample,
  input  logic                sample_valid,
  output logic                sample_ready,
  output logic [31:0]         payoff_base,
  output logic [31:0]         payoff_up,
  output logic [31:0]         payoff_down,
  output logic [62:0]         total_base,
  output logic [62:0]         total_up,
  output logic [62:0]         total_down,
  output logic [23:0]         paths_done,
  output logic                run_last,
  output logic                result_valid,
  input  logic                result_ready
);

  localparam int SBW = $clog2(MAX_STEPS + 1);
  localparam int NW  = (SBW > 13) ? SBW : 13;
  localparam int PW  = mcope_pkg::PSUM_W;
  localparam int TW  = mcope_pkg::TOTAL_W;
  localparam int MW  = mcope_pkg::MUL_W;

  // Configuration registers.
  logic [31:0]        spot_price;
  logic [31:0]        strike_price;
  logic [16:0]        bump_size;
  logic signed [31:0] drift_term;
  logic [30:0]        vol_term;
  logic [12:0]        steps_per_path;
  logic [2:0]         option_kind;
  logic [23:0]        paths_total;

  mcope_pkg::state_t state, state_next;

  logic signed [15:0] z_reg;
  logic signed [29:0] x24;
  logic signed [6:0]  k_reg;
  logic [29:0]        t_reg;
  logic [31:0]        m_reg;
  logic [31:0]        v_reg;
  logic [2:0]         pidx;
  logic [1:0]         lane;
  logic [31:0]        price [3];
  logic [PW-1:0]      psum [3];
  logic [NW-1:0]      day_count;
  logic [TW-1:0]      tsum [3];
  logic [23:0]        path_count;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;

  logic                   div_start;
  logic [PW-1:0]          quot [3];
  mcope_pkg::div_stat_t   div_stat;

  logic cfg_wr;
  logic load_out;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      spot_price     <= mcope_pkg::SPOT_RST;
      strike_price   <= mcope_pkg::STRIKE_RST;
      bump_size      <= mcope_pkg::BUMP_RST;
      drift_term     <= '0;
      vol_term       <= mcope_pkg::VOL_RST;
      steps_per_path <= 13'd1;
      option_kind    <= mcope_pkg::KIND_CALL;
      paths_total    <= 24'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        mcope_pkg::REG_SPOT:   spot_price     <= pwdata;
        mcope_pkg::REG_STRIKE: strike_price   <= pwdata;
        mcope_pkg::REG_BUMP:   bump_size      <= pwdata[16:0];
        mcope_pkg::REG_DRIFT:  drift_term     <= pwdata;
        mcope_pkg::REG_VOL:    vol_term       <= pwdata[30:0];
        mcope_pkg::REG_STEPS:  steps_per_path <= pwdata[12:0];
        mcope_pkg::REG_KIND:   option_kind    <= pwdata[2:0];
        mcope_pkg::REG_PATHS:  paths_total    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      mcope_pkg::REG_SPOT:   prdata = spot_price;
      mcope_pkg::REG_STRIKE: prdata = strike_price;
      mcope_pkg::REG_BUMP:   prdata = {15'b0, bump_size};
      mcope_pkg::REG_DRIFT:  prdata = drift_term;
      mcope_pkg::REG_VOL:    prdata = {1'b0, vol_term};
      mcope_pkg::REG_STEPS:  prdata = {19'b0, steps_per_path};
      mcope_pkg::REG_KIND:   prdata = {29'b0, option_kind};
      mcope_pkg::REG_PATHS:  prdata = {8'b0, paths_total};
      default:               prdata = '0;
    endcase
  end

  // Effective step count: zero acts as one, large values clamp to MAX_STEPS.
  logic [NW-1:0] nsteps;
  always_comb begin
    if (steps_per_path == 13'd0) begin
      nsteps = NW'(1);
    end else if (NW'(steps_per_path) > NW'(MAX_STEPS)) begin
      nsteps = NW'(MAX_STEPS);
    end else begin
      nsteps = NW'(steps_per_path);
    end
  end

  // Datapath terms read from the shared product register.
  logic signed [47:0] x42, x42_adj;
  logic [31:0]        v_now;
  logic [2:0]         n_cur;
  logic [31:0]        q0;
  logic [34:0]        q0n, rem_c;
  logic [31:0]        q_fix;
  logic signed [7:0]  shamt;
  logic [63:0]        gshift;
  logic [31:0]        grown;
  logic [PW:0]        psum_add;
  logic [NW-1:0]      day_inc;

  always_comb begin
    x42     = $signed(prod[47:0]) + $signed({{4{drift_term[31]}}, drift_term, 12'b0});
    // Truncate toward zero when dropping eighteen fraction bits.
    x42_adj = x42 + (x42[47] ? 48'sd262143 : 48'sd0);
    v_now   = prod[61:30];
    n_cur   = 3'd6 - pidx;
    q0      = prod[63:32];
    q0n     = 35'(q0) * 35'(n_cur);
    rem_c   = {3'b0, v_reg} - q0n;
    if (rem_c >= 35'({n_cur, 1'b0})) begin
      q_fix = q0 + 32'd2;
    end else if (rem_c >= 35'(n_cur)) begin
      q_fix = q0 + 32'd1;
    end else begin
      q_fix = q0;
    end
    shamt  = 8'sd30 - {k_reg[6], k_reg};
    gshift = prod[63:0] >> shamt[5:0];
    if (shamt <= 8'sd0) begin
      grown = (price[lane] != 32'd0) ? 32'hFFFF_FFFF : 32'd0;
    end else if (shamt >= 8'sd64) begin
      grown = 32'd0;
    end else if (gshift[63:32] != 32'd0) begin
      grown = 32'hFFFF_FFFF;
    end else begin
      grown = gshift[31:0];
    end
    psum_add = {1'b0, psum[lane]} + (PW + 1)'(grown);
    day_inc  = day_count + 1'b1;
  end

  // Shared multiplier operands.
  always_comb begin
    unique case (state)
      mcope_pkg::ST_XMUL: begin
        mul_a = {3'b0, vol_term};
        mul_b = {{(MW-16){z_reg[15]}}, z_reg};
      end
      mcope_pkg::ST_LOG: begin
        mul_a = {{(MW-30){x24[29]}}, x24};
        mul_b = {3'b0, mcope_pkg::LOG2E_Q30};
      end
      mcope_pkg::ST_TMUL: begin
        mul_a = {4'b0, prod[53:24]};
        mul_b = {4'b0, mcope_pkg::LN2_Q30};
      end
      mcope_pkg::ST_PMUL: begin
        mul_a = {2'b0, m_reg};
        mul_b = {4'b0, t_reg};
      end
      mcope_pkg::ST_PREC: begin
        mul_a = {2'b0, v_now};
        mul_b = {1'b0, mcope_pkg::recip(n_cur)};
      end
      mcope_pkg::ST_GMUL: begin
        mul_a = {2'b0, price[lane]};
        mul_b = {2'b0, m_reg};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mcope_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mcope_div #(
    .SW (PW),
    .DW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (nsteps),
    .dividend (psum),
    .quotient (quot),
    .stat     (div_stat)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mcope_pkg::ST_IDLE:   if (sample_valid) state_next = mcope_pkg::ST_XMUL;
      mcope_pkg::ST_XMUL:   state_next = mcope_pkg::ST_TRUNC;
      mcope_pkg::ST_TRUNC:  state_next = mcope_pkg::ST_LOG;
      mcope_pkg::ST_LOG:    state_next = mcope_pkg::ST_TMUL;
      mcope_pkg::ST_TMUL:   state_next = mcope_pkg::ST_TREG;
      mcope_pkg::ST_TREG:   state_next = mcope_pkg::ST_PMUL;
      mcope_pkg::ST_PMUL:   state_next = mcope_pkg::ST_PREC;
      mcope_pkg::ST_PREC:   state_next = mcope_pkg::ST_PCOR;
      mcope_pkg::ST_PCOR: begin
        state_next = (pidx == 3'd5) ? mcope_pkg::ST_GMUL : mcope_pkg::ST_PMUL;
      end
      mcope_pkg::ST_GMUL:   state_next = mcope_pkg::ST_GAPPLY;
      mcope_pkg::ST_GAPPLY: begin
        state_next = (lane == 2'd2) ? mcope_pkg::ST_CHECK : mcope_pkg::ST_GMUL;
      end
      mcope_pkg::ST_CHECK: begin
        state_next = (day_inc >= nsteps) ? mcope_pkg::ST_DIV : mcope_pkg::ST_IDLE;
      end
      mcope_pkg::ST_DIV:    if (div_stat.done) state_next = mcope_pkg::ST_PAY;
      mcope_pkg::ST_PAY:    if (load_out) state_next = mcope_pkg::ST_IDLE;
      default:              state_next = mcope_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    sample_ready = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      mcope_pkg::ST_IDLE:  sample_ready = 1'b1;
      mcope_pkg::ST_CHECK: div_start = (day_inc >= nsteps);
      mcope_pkg::ST_PAY:   load_out = ~result_valid | result_ready;
      default: ;
    endcase
  end

  // Path end: averages, payoffs and totals.
  logic [31:0] avg [3];
  logic [31:0] pay [3];
  logic [TW:0] tadd [3];
  logic [TW-1:0] tnew [3];
  logic [23:0] done_cnt;
  logic        last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      avg[i] = (quot[i][PW-1:32] != '0) ? 32'hFFFF_FFFF : quot[i][31:0];
      unique case (option_kind)
        mcope_pkg::KIND_CALL:
          pay[i] = (price[i] > strike_price) ? price[i] - strike_price : 32'd0;
        mcope_pkg::KIND_PUT:
          pay[i] = (strike_price > price[i]) ? strike_price - price[i] : 32'd0;
        mcope_pkg::KIND_FIXED_CALL:
          pay[i] = (avg[i] > strike_price) ? avg[i] - strike_price : 32'd0;
        mcope_pkg::KIND_FIXED_PUT:
          pay[i] = (strike_price > avg[i]) ? strike_price - avg[i] : 32'd0;
        mcope_pkg::KIND_FLOAT_CALL:
          pay[i] = (price[i] > avg[i]) ? price[i] - avg[i] : 32'd0;
        mcope_pkg::KIND_FLOAT_PUT:
          pay[i] = (avg[i] > price[i]) ? avg[i] - price[i] : 32'd0;
        default:
          pay[i] = 32'd0;
      endcase
      tadd[i] = {1'b0, tsum[i]} + (TW + 1)'(pay[i]);
      tnew[i] = tadd[i][TW] ? {TW{1'b1}} : tadd[i][TW-1:0];
    end
    done_cnt = path_count + 24'd1;
    last     = (done_cnt == paths_total);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mcope_pkg::ST_IDLE;
      result_valid <= 1'b0;
      pidx         <= '0;
      lane         <= '0;
      day_count    <= '0;
      path_count   <= '0;
      for (int i = 0; i < 3; i++) begin
        psum[i] <= '0;
        tsum[i] <= '0;
      end
      price[0] <= mcope_pkg::SPOT_RST;
      price[1] <= mcope_pkg::start_up(mcope_pkg::SPOT_RST, mcope_pkg::BUMP_RST);
      price[2] <= mcope_pkg::start_down(mcope_pkg::SPOT_RST, mcope_pkg::BUMP_RST);
    end else begin
      state <= state_next;
      // A new word loaded in the same cycle keeps the valid flag set.
      if (result_valid && result_ready && !load_out) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        mcope_pkg::ST_TMUL: pidx <= '0;
        mcope_pkg::ST_PCOR: begin
          pidx <= pidx + 3'd1;
          lane <= '0;
        end
        mcope_pkg::ST_GAPPLY: begin
          price[lane] <= grown;
          psum[lane]  <= psum_add[PW] ? {PW{1'b1}} : psum_add[PW-1:0];
          lane        <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
        end
        mcope_pkg::ST_CHECK: day_count <= day_inc;
        mcope_pkg::ST_PAY: begin
          if (load_out) begin
            result_valid <= 1'b1;
            path_count   <= last ? 24'd0 : done_cnt;
            for (int i = 0; i < 3; i++) begin
              tsum[i] <= last ? '0 : tnew[i];
              psum[i] <= '0;
            end
            day_count <= '0;
            price[0]  <= spot_price;
            price[1]  <= mcope_pkg::start_up(spot_price, bump_size);
            price[2]  <= mcope_pkg::start_down(spot_price, bump_size);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      z_reg <= normal_sample;
    end
    if (state == mcope_pkg::ST_TRUNC) begin
      x24 <= x42_adj[47:18];
    end
    if (state == mcope_pkg::ST_TMUL) begin
      k_reg <= prod[60:54];
      m_reg <= mcope_pkg::ONE_Q30;
    end
    if (state == mcope_pkg::ST_TREG) begin
      t_reg <= prod[59:30];
    end
    if (state == mcope_pkg::ST_PREC) begin
      v_reg <= v_now;
    end
    if (state == mcope_pkg::ST_PCOR) begin
      m_reg <= mcope_pkg::ONE_Q30 + q_fix;
    end
    if (load_out) begin
      payoff_base <= pay[0];
      payoff_up   <= pay[1];
      payoff_down <= pay[2];
      total_base  <= tnew[0];
      total_up    <= tnew[1];
      total_down  <= tnew[2];
      paths_done  <= done_cnt;
      run_last    <= last;
    end
  end

endmodule

// ===== rtl/core/mcope_check.sv =====
// Port-level checker for the path engine, bound to the top level.
`timescale 1ns / 1ps
`include "monte_carlo_option_path_engine_top_assert.svh"
module mcope_check (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] payoff_base,
  input logic [31:0] payoff_up,
  input logic [31:0] payoff_down,
  input logic [62:0] total_base,
  input logic [62:0] total_up,
  input logic [62:0] total_down,
  input logic [23:0] paths_done
);

  // Accepting a sample leaves the engine busy, with sample_ready low.
  `MCOPE_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "ready after accept")

  // Each total already includes the payoff shown with it.
  `MCOPE_ASSERT_NOW(a_total_covers_payoff, result_valid, (total_base >= 63'(payoff_base)) && (total_up >= 63'(payoff_up)) && (total_down >= 63'(payoff_down)), "total below payoff")

  `MCOPE_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(paths_done) && $stable(total_base), "stalled result changed")

  `MCOPE_ASSERT_NOW(a_no_result_after_reset, $past(rst), !result_valid, "result right after reset")

endmodule

bind monte_carlo_option_path_engine_top mcope_check u_mcope_check (.*);
